@@ hw/rtl/assert_macros.svh @@
// assertion macros used by button_gesture_detector.sv
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLY(label, pre, post, msg)
`endif

`endif

@@ hw/rtl/bgd_pkg.sv @@
// types and constants of the button gesture detector
// no dependencies
package bgd_pkg;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_SHORT  = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_DOUBLE_WINDOW   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SHORT_HOLD_TIME = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_HOLD_TIME  = 2'd2;

  localparam logic [CfgDataW-1:0] DOUBLE_WINDOW_RST   = 16'd300;
  localparam logic [CfgDataW-1:0] SHORT_HOLD_TIME_RST = 16'd500;
  localparam logic [CfgDataW-1:0] LONG_HOLD_TIME_RST  = 16'd1500;

  localparam int NowW = 32;

endpackage

@@ hw/rtl/button_gesture_detector.sv @@
// button gesture detector: click, double click, short and long hold from polls
// depends on bgd_pkg and assert_macros.svh
//
//   channel  dir  handshake                 contents
//   s_       in   s_tvalid / s_tready       one poll word: pin level, timestamp
//   m_       out  m_tvalid / m_tready       one event word per poll
//   cfg_     in   cfg_valid / cfg_ready     register index and 16 bit value
//
// one poll per cycle while s_tready is high; each event appears in the cycle after its poll is taken
// the gesture state and the event register update in the same edge
// a stalled event holds while polls wait; s_tready drops only then
// cfg_ready is always high
// rst clears state and loads the register defaults
`include "assert_macros.svh"

module button_gesture_detector
  import bgd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,   // pin_level [0], now_ms [32:1], zero pad
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // event_res [2:0], zero pad
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int TakeW = (TIME_BITS < NowW) ? TIME_BITS : NowW;

  logic [CfgDataW-1:0]  double_window;
  logic [CfgDataW-1:0]  short_hold_time;
  logic [CfgDataW-1:0]  long_hold_time;

  logic                 press_active, press_active_next;
  logic                 long_done, long_done_next;
  logic                 second_press, second_press_next;
  logic                 click_pending, click_pending_next;
  logic [TIME_BITS-1:0] press_start_time, press_start_time_next;
  logic [TIME_BITS-1:0] last_release_time, last_release_time_next;
  event_t               event_q, event_next;

  logic                 take;
  logic                 pressed;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] win_t, short_t, long_t;
  logic [TIME_BITS-1:0] el_rel, el_press, el_pend;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign take      = s_tvalid && s_tready;
  assign m_tdata   = {5'd0, event_q};

  assign pressed  = !s_tdata[0];
  assign now_t    = TIME_BITS'(s_tdata[TakeW:1]);
  assign win_t    = TIME_BITS'(double_window);
  assign short_t  = TIME_BITS'(short_hold_time);
  assign long_t   = TIME_BITS'(long_hold_time);
  assign el_rel   = now_t - last_release_time;
  assign el_press = now_t - press_start_time;

  always_comb begin
    press_active_next      = press_active;
    long_done_next         = long_done;
    second_press_next      = second_press;
    click_pending_next     = click_pending;
    press_start_time_next  = press_start_time;
    last_release_time_next = last_release_time;
    event_next             = EV_NONE;
    el_pend                = el_rel;
    if (pressed) begin
      if (!long_done) begin
        if (!press_active) begin
          press_active_next     = 1'b1;
          press_start_time_next = now_t;
          if (el_rel <= win_t) begin
            second_press_next = 1'b1;
          end
        end else if (el_press > long_t) begin
          press_active_next = 1'b0;
          second_press_next = 1'b0;
          long_done_next    = 1'b1;
          event_next        = EV_LONG;
        end
      end
    end else begin
      if (press_active) begin
        press_active_next = 1'b0;
        if (second_press) begin
          second_press_next  = 1'b0;
          click_pending_next = 1'b0;
          event_next         = EV_DOUBLE;
        end else if (el_press > short_t) begin
          click_pending_next = 1'b0;
          event_next         = EV_SHORT;
        end else begin
          click_pending_next     = 1'b1;
          last_release_time_next = now_t;
        end
      end
      // el_pend uses the release time chosen above
      el_pend = now_t - last_release_time_next;
      if (click_pending_next && el_pend > win_t) begin
        click_pending_next = 1'b0;
        event_next         = EV_CLICK;
      end
      long_done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      double_window   <= DOUBLE_WINDOW_RST;
      short_hold_time <= SHORT_HOLD_TIME_RST;
      long_hold_time  <= LONG_HOLD_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DOUBLE_WINDOW:   double_window   <= cfg_data;
        REG_SHORT_HOLD_TIME: short_hold_time <= cfg_data;
        REG_LONG_HOLD_TIME:  long_hold_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_active      <= 1'b0;
      long_done         <= 1'b0;
      second_press      <= 1'b0;
      click_pending     <= 1'b0;
      press_start_time  <= '0;
      last_release_time <= '0;
      m_tvalid          <= 1'b0;
      event_q           <= EV_NONE;
    end else begin
      if (take) begin
        press_active      <= press_active_next;
        long_done         <= long_done_next;
        second_press      <= second_press_next;
        click_pending     <= click_pending_next;
        press_start_time  <= press_start_time_next;
        last_release_time <= last_release_time_next;
        event_q           <= event_next;
        m_tvalid          <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_long_not_active, !(long_done && press_active), "long hold while press tracked")
  `ASSERT_IMPLY(a_second_in_press, second_press, press_active, "second press without press")
  `ASSERT_IMPLY(a_long_event_flag, m_tvalid && event_q == EV_LONG, long_done, "long event without flag")

endmodule
